[src/ray_triangle_hit_test_macros.svh]
// Assertion macros for the ray/triangle hit test block.
// Used by the port checker; expects aclk and aresetn in scope.
`ifndef RAY_TRIANGLE_HIT_TEST_MACROS_SVH
`define RAY_TRIANGLE_HIT_TEST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rth_pkg.sv]
// Shared types, widths and codes of the ray/triangle hit test block.
// No dependencies; the other files refer to it by scoped names or import it.
package rth_pkg;

    // Fixed field widths of the channels
    localparam int FIELD_W  = 32;
    localparam int INDEX_W  = 10;
    localparam int CMD_W    = 2;
    localparam int DIST_W   = 16;
    localparam int T_W      = 31;
    localparam int T_FRAC_W = 16;

    // Store and coordinate sizing
    localparam int VERTEX_COUNT = 1024;
    localparam int ADDR_W       = $clog2(VERTEX_COUNT);
    localparam int COORD_W      = 32;
    localparam int VERT_W       = 3 * COORD_W;

    // Datapath widths, exact at every step
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD1_W  = 2 * DIFF_W;
    localparam int MINOR_W  = PROD1_W + 1;
    localparam int LO_W     = DIFF_W;
    localparam int HI_W     = MINOR_W - LO_W;
    localparam int LOP_W    = DIFF_W + LO_W + 1;
    localparam int HIP_W    = DIFF_W + HI_W;
    localparam int PROD2_W  = DIFF_W + MINOR_W;
    localparam int SUM_W    = PROD2_W + 2;
    localparam int SAT_SH   = T_W - T_FRAC_W;
    localparam int NUM_PROD = 12;
    localparam int CRAMER_STAGES = 7;
    localparam int DIV_STEPS     = T_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE_VERTEX = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_RAY     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEST         = 2'd2;
    // Spare code: accepted and dropped, no result
    localparam logic [CMD_W-1:0] CMD_IGNORED      = 2'd3;

    localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [INDEX_W-1:0]        first_index;
        logic [INDEX_W-1:0]        second_index;
        logic [INDEX_W-1:0]        third_index;
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_z;
        logic signed [FIELD_W-1:0] dir_x;
        logic signed [FIELD_W-1:0] dir_y;
        logic signed [FIELD_W-1:0] dir_z;
    } in_item_t;

    typedef struct packed {
        logic           hit;
        logic [T_W-1:0] hit_distance;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vec_t;

    // Per-item control that rides along the pipeline
    typedef struct packed {
        logic valid;
        logic ok;
        logic sat;
    } pipe_tag_t;

    function automatic logic signed [COORD_W-1:0] coord_in(input logic signed [FIELD_W-1:0] f);
        return COORD_W'(f);
    endfunction

endpackage

[src/rth_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/rth_cramer.sv]
// Cramer's rule front end: edge differences, 2x2 minors and the four 3x3 sums.
// Seven register stages; depends on rth_pkg.
module rth_cramer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  rth_pkg::pipe_tag_t                tag_i,
    input  rth_pkg::vec_t                     v0_i,
    input  rth_pkg::vec_t                     v1_i,
    input  rth_pkg::vec_t                     v2_i,
    input  rth_pkg::vec_t                     org_i,
    input  rth_pkg::vec_t                     dir_i,
    output rth_pkg::pipe_tag_t                tag_o,
    output logic signed [rth_pkg::SUM_W-1:0]  den_o,
    output logic signed [rth_pkg::SUM_W-1:0]  e1_o,
    output logic signed [rth_pkg::SUM_W-1:0]  e2_o,
    output logic signed [rth_pkg::SUM_W-1:0]  e3_o
);

    rth_pkg::pipe_tag_t tag_reg [rth_pkg::CRAMER_STAGES];

    // stage A: differences
    logic signed [rth_pkg::DIFF_W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg;
    logic signed [rth_pkg::DIFF_W-1:0] g_reg, h_reg, i_reg, j_reg, k_reg, l_reg;
    // stage B: products of the minors
    logic signed [rth_pkg::PROD1_W-1:0] fk_reg, gj_reg, hk_reg, gl_reg, fl_reg, hj_reg;
    logic signed [rth_pkg::PROD1_W-1:0] gi_reg, ek_reg, ej_reg, fi_reg, el_reg, hi_reg;
    logic signed [rth_pkg::DIFF_W-1:0]  a2_reg, b2_reg, c2_reg, d2_reg;
    // stage C: minors
    logic signed [rth_pkg::MINOR_W-1:0] m_reg, n_reg, p_reg, q_reg, s_reg, r_reg;
    logic signed [rth_pkg::DIFF_W-1:0]  a3_reg, b3_reg, c3_reg, d3_reg;
    // stage D: partial products, stage E: full products
    logic signed [rth_pkg::DIFF_W-1:0]  op_d [rth_pkg::NUM_PROD];
    logic signed [rth_pkg::MINOR_W-1:0] op_m [rth_pkg::NUM_PROD];
    logic signed [rth_pkg::LOP_W-1:0]   lo_reg [rth_pkg::NUM_PROD];
    logic signed [rth_pkg::HIP_W-1:0]   hi_part_reg [rth_pkg::NUM_PROD];
    logic signed [rth_pkg::PROD2_W-1:0] prod_reg [rth_pkg::NUM_PROD];
    // stages F and G: sums
    logic signed [rth_pkg::SUM_W-1:0]   den_f_reg, e1_f_reg, e2_f_reg, e3_f_reg;
    logic signed [rth_pkg::PROD2_W-1:0] den_t_reg, e1_t_reg, e2_t_reg, e3_t_reg;
    logic signed [rth_pkg::SUM_W-1:0]   den_reg, e1_reg, e2_reg, e3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int st = 0; st < rth_pkg::CRAMER_STAGES; st++) begin
                tag_reg[st] <= '0;
            end
        end else if (adv) begin
            tag_reg[0] <= tag_i;
            for (int st = 1; st < rth_pkg::CRAMER_STAGES; st++) begin
                tag_reg[st] <= tag_reg[st-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg <= rth_pkg::DIFF_W'(v0_i.x) - rth_pkg::DIFF_W'(v1_i.x);
            b_reg <= rth_pkg::DIFF_W'(v0_i.x) - rth_pkg::DIFF_W'(v2_i.x);
            c_reg <= rth_pkg::DIFF_W'(dir_i.x);
            d_reg <= rth_pkg::DIFF_W'(v0_i.x) - rth_pkg::DIFF_W'(org_i.x);
            e_reg <= rth_pkg::DIFF_W'(v0_i.y) - rth_pkg::DIFF_W'(v1_i.y);
            f_reg <= rth_pkg::DIFF_W'(v0_i.y) - rth_pkg::DIFF_W'(v2_i.y);
            g_reg <= rth_pkg::DIFF_W'(dir_i.y);
            h_reg <= rth_pkg::DIFF_W'(v0_i.y) - rth_pkg::DIFF_W'(org_i.y);
            i_reg <= rth_pkg::DIFF_W'(v0_i.z) - rth_pkg::DIFF_W'(v1_i.z);
            j_reg <= rth_pkg::DIFF_W'(v0_i.z) - rth_pkg::DIFF_W'(v2_i.z);
            k_reg <= rth_pkg::DIFF_W'(dir_i.z);
            l_reg <= rth_pkg::DIFF_W'(v0_i.z) - rth_pkg::DIFF_W'(org_i.z);

            fk_reg <= rth_pkg::PROD1_W'(f_reg) * rth_pkg::PROD1_W'(k_reg);
            gj_reg <= rth_pkg::PROD1_W'(g_reg) * rth_pkg::PROD1_W'(j_reg);
            hk_reg <= rth_pkg::PROD1_W'(h_reg) * rth_pkg::PROD1_W'(k_reg);
            gl_reg <= rth_pkg::PROD1_W'(g_reg) * rth_pkg::PROD1_W'(l_reg);
            fl_reg <= rth_pkg::PROD1_W'(f_reg) * rth_pkg::PROD1_W'(l_reg);
            hj_reg <= rth_pkg::PROD1_W'(h_reg) * rth_pkg::PROD1_W'(j_reg);
            gi_reg <= rth_pkg::PROD1_W'(g_reg) * rth_pkg::PROD1_W'(i_reg);
            ek_reg <= rth_pkg::PROD1_W'(e_reg) * rth_pkg::PROD1_W'(k_reg);
            ej_reg <= rth_pkg::PROD1_W'(e_reg) * rth_pkg::PROD1_W'(j_reg);
            fi_reg <= rth_pkg::PROD1_W'(f_reg) * rth_pkg::PROD1_W'(i_reg);
            el_reg <= rth_pkg::PROD1_W'(e_reg) * rth_pkg::PROD1_W'(l_reg);
            hi_reg <= rth_pkg::PROD1_W'(h_reg) * rth_pkg::PROD1_W'(i_reg);
            a2_reg <= a_reg;
            b2_reg <= b_reg;
            c2_reg <= c_reg;
            d2_reg <= d_reg;

            m_reg  <= rth_pkg::MINOR_W'(fk_reg) - rth_pkg::MINOR_W'(gj_reg);
            n_reg  <= rth_pkg::MINOR_W'(hk_reg) - rth_pkg::MINOR_W'(gl_reg);
            p_reg  <= rth_pkg::MINOR_W'(fl_reg) - rth_pkg::MINOR_W'(hj_reg);
            q_reg  <= rth_pkg::MINOR_W'(gi_reg) - rth_pkg::MINOR_W'(ek_reg);
            s_reg  <= rth_pkg::MINOR_W'(ej_reg) - rth_pkg::MINOR_W'(fi_reg);
            r_reg  <= rth_pkg::MINOR_W'(el_reg) - rth_pkg::MINOR_W'(hi_reg);
            a3_reg <= a2_reg;
            b3_reg <= b2_reg;
            c3_reg <= c2_reg;
            d3_reg <= d2_reg;
        end
    end

    // Operand pairing of the twelve long products, three per sum:
    // den = a*m + b*q + c*s, e1 = d*m - b*n - c*p,
    // e2 = a*n + d*q + c*r, e3 = a*p - b*r + d*s
    always_comb begin
        op_d[0]  = a3_reg;  op_m[0]  = m_reg;
        op_d[1]  = b3_reg;  op_m[1]  = q_reg;
        op_d[2]  = c3_reg;  op_m[2]  = s_reg;
        op_d[3]  = d3_reg;  op_m[3]  = m_reg;
        op_d[4]  = b3_reg;  op_m[4]  = n_reg;
        op_d[5]  = c3_reg;  op_m[5]  = p_reg;
        op_d[6]  = a3_reg;  op_m[6]  = n_reg;
        op_d[7]  = d3_reg;  op_m[7]  = q_reg;
        op_d[8]  = c3_reg;  op_m[8]  = r_reg;
        op_d[9]  = a3_reg;  op_m[9]  = p_reg;
        op_d[10] = b3_reg;  op_m[10] = r_reg;
        op_d[11] = d3_reg;  op_m[11] = s_reg;
    end

    // Split each long product into a low (unsigned) and a high (signed) half
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int t = 0; t < rth_pkg::NUM_PROD; t++) begin
                lo_reg[t] <= rth_pkg::LOP_W'(op_d[t])
                           * rth_pkg::LOP_W'($signed({1'b0, op_m[t][rth_pkg::LO_W-1:0]}));
                hi_part_reg[t] <= rth_pkg::HIP_W'(op_d[t])
                           * rth_pkg::HIP_W'($signed(op_m[t][rth_pkg::MINOR_W-1:rth_pkg::LO_W]));
                prod_reg[t] <= (rth_pkg::PROD2_W'(hi_part_reg[t]) <<< rth_pkg::LO_W)
                             + rth_pkg::PROD2_W'(lo_reg[t]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            den_f_reg <= rth_pkg::SUM_W'(prod_reg[0]) + rth_pkg::SUM_W'(prod_reg[1]);
            e1_f_reg  <= rth_pkg::SUM_W'(prod_reg[3]) - rth_pkg::SUM_W'(prod_reg[4]);
            e2_f_reg  <= rth_pkg::SUM_W'(prod_reg[6]) + rth_pkg::SUM_W'(prod_reg[7]);
            e3_f_reg  <= rth_pkg::SUM_W'(prod_reg[9]) - rth_pkg::SUM_W'(prod_reg[10]);
            den_t_reg <= prod_reg[2];
            e1_t_reg  <= prod_reg[5];
            e2_t_reg  <= prod_reg[8];
            e3_t_reg  <= prod_reg[11];

            den_reg <= den_f_reg + rth_pkg::SUM_W'(den_t_reg);
            e1_reg  <= e1_f_reg - rth_pkg::SUM_W'(e1_t_reg);
            e2_reg  <= e2_f_reg + rth_pkg::SUM_W'(e2_t_reg);
            e3_reg  <= e3_f_reg + rth_pkg::SUM_W'(e3_t_reg);
        end
    end

    assign tag_o = tag_reg[rth_pkg::CRAMER_STAGES-1];
    assign den_o = den_reg;
    assign e1_o  = e1_reg;
    assign e2_o  = e2_reg;
    assign e3_o  = e3_reg;

endmodule

[src/rth_divider.sv]
// Restoring divider, one quotient bit per register stage.
// Depends on rth_pkg.
module rth_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  rth_pkg::pipe_tag_t         tag_i,
    input  logic [rth_pkg::SUM_W-1:0]  den_i,
    input  logic [rth_pkg::SUM_W-1:0]  rem_i,
    input  logic [rth_pkg::T_W-1:0]    word_i,
    output rth_pkg::pipe_tag_t         tag_o,
    output logic [rth_pkg::T_W-1:0]    quo_o
);

    rth_pkg::pipe_tag_t            tag_reg  [rth_pkg::DIV_STEPS];
    logic [rth_pkg::T_W-1:0]       word_reg [rth_pkg::DIV_STEPS];
    logic [rth_pkg::SUM_W-1:0]     den_reg  [rth_pkg::DIV_STEPS-1];
    logic [rth_pkg::SUM_W-1:0]     rem_reg  [rth_pkg::DIV_STEPS-1];

    // word holds the unconsumed dividend bits on top and the quotient bits below
    for (genvar k = 0; k < rth_pkg::DIV_STEPS; k++) begin : g_step
        rth_pkg::pipe_tag_t        tag_s;
        logic [rth_pkg::SUM_W-1:0] den_s;
        logic [rth_pkg::SUM_W-1:0] rem_s;
        logic [rth_pkg::T_W-1:0]   word_s;
        logic [rth_pkg::SUM_W:0]   trial;
        logic [rth_pkg::SUM_W:0]   diff;
        logic                      take;

        if (k == 0) begin : g_head
            assign tag_s  = tag_i;
            assign den_s  = den_i;
            assign rem_s  = rem_i;
            assign word_s = word_i;
        end else begin : g_tail
            assign tag_s  = tag_reg[k-1];
            assign den_s  = den_reg[k-1];
            assign rem_s  = rem_reg[k-1];
            assign word_s = word_reg[k-1];
        end

        always_comb begin
            trial = {rem_s, word_s[rth_pkg::T_W-1]};
            diff  = trial - {1'b0, den_s};
            take  = (trial >= {1'b0, den_s});
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[k] <= '0;
            end else if (adv) begin
                tag_reg[k] <= tag_s;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                word_reg[k] <= {word_s[rth_pkg::T_W-2:0], take};
            end
        end

        if (k < rth_pkg::DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (adv) begin
                    den_reg[k] <= den_s;
                    rem_reg[k] <= take ? diff[rth_pkg::SUM_W-1:0] : trial[rth_pkg::SUM_W-1:0];
                end
            end
        end
    end

    assign tag_o = tag_reg[rth_pkg::DIV_STEPS-1];
    assign quo_o = word_reg[rth_pkg::DIV_STEPS-1];

endmodule

[src/ray_triangle_hit_test.sv]
// Ray/triangle hit test, top level: command decode, vertex store, ray state,
// hit decision and output buffering. Depends on rth_pkg, rth_ram, rth_cramer
// and rth_divider.
//
// The block takes one command transfer per cycle while s_ready is high. A vertex
// write lands in the store at its transfer; a ray load replaces the current ray
// at its transfer; a triangle test enters a 43-stage pipeline (one store read,
// seven Cramer stages, three decision stages, 31 divider stages, one final
// stage) followed by the output register, and its result appears on the m_
// side in order. Tests already in flight keep the ray that was current when
// they were taken. Throughput is set by the pipeline, which holds all stages
// still only while a second result waits behind an unread one; latency is set
// by the bit-per-stage divider that produces t. The vertex store is three
// copies of one 1024 x 96-bit RAM, one per triangle corner, all written
// together; it has no clearing pass, so a test must name only vertices written
// earlier.
// t is exact: floor of the quotient in Q15.16, saturated to 0x7FFFFFFF; a zero
// determinant, a negative barycentric, beta plus gamma above one, or t below
// min_distance is a miss with hit_distance zero. min_distance resets to 1; the
// user must write it through cfg_wr_en/cfg_wr_data while the block is idle (unenforced).
module ray_triangle_hit_test (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rth_pkg::in_item_t             s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rth_pkg::out_item_t            m_item,
    input  logic                          cfg_wr_en,
    input  logic [rth_pkg::DIST_W-1:0]    cfg_wr_data
);

    logic                         pipe_en;
    logic                         s_xfer;
    logic                         is_write;
    logic                         is_load;
    logic                         is_test;
    logic                         idx_ok;
    rth_pkg::vec_t                wr_vec;

    logic [rth_pkg::DIST_W-1:0]   min_distance_reg;
    rth_pkg::vec_t                org_reg;
    rth_pkg::vec_t                dir_reg;

    // stage 1: store read
    rth_pkg::pipe_tag_t           s1_tag_reg;
    rth_pkg::vec_t                s1_org_reg;
    rth_pkg::vec_t                s1_dir_reg;
    logic [rth_pkg::VERT_W-1:0]   v0_raw;
    logic [rth_pkg::VERT_W-1:0]   v1_raw;
    logic [rth_pkg::VERT_W-1:0]   v2_raw;

    rth_pkg::pipe_tag_t                cr_tag;
    logic signed [rth_pkg::SUM_W-1:0]  cr_den;
    logic signed [rth_pkg::SUM_W-1:0]  cr_e1;
    logic signed [rth_pkg::SUM_W-1:0]  cr_e2;
    logic signed [rth_pkg::SUM_W-1:0]  cr_e3;
    logic                              den_neg;

    // stage H: sign normalization
    rth_pkg::pipe_tag_t                h_tag_reg;
    logic [rth_pkg::SUM_W-1:0]         h_den_reg;
    logic signed [rth_pkg::SUM_W-1:0]  h_e1_reg;
    logic signed [rth_pkg::SUM_W-1:0]  h_e2_reg;
    logic signed [rth_pkg::SUM_W-1:0]  h_e3_reg;
    // stage I: sign checks, beta plus gamma, saturation
    rth_pkg::pipe_tag_t                i_tag_reg;
    logic [rth_pkg::SUM_W-1:0]         i_den_reg;
    logic [rth_pkg::SUM_W-1:0]         i_e3_reg;
    logic [rth_pkg::SUM_W:0]           i_sum_reg;
    // stage J: bound check and divider setup
    rth_pkg::pipe_tag_t                j_tag_reg;
    logic [rth_pkg::SUM_W-1:0]         j_den_reg;
    logic [rth_pkg::SUM_W-1:0]         j_rem_reg;
    logic [rth_pkg::T_W-1:0]           j_word_reg;

    rth_pkg::pipe_tag_t                dv_tag;
    logic [rth_pkg::T_W-1:0]           dv_quo;
    logic                              fin_hit;

    // final stage and output buffering
    logic                         fin_valid_reg;
    rth_pkg::out_item_t           fin_item_reg;
    logic                         m_valid_reg;
    rth_pkg::out_item_t           m_item_reg;
    logic                         skid_valid_reg;
    rth_pkg::out_item_t           skid_item_reg;

    // The whole pipeline moves while the skid slot is empty
    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        is_write = 1'b0;
        is_load  = 1'b0;
        is_test  = 1'b0;
        unique case (s_item.cmd)
            rth_pkg::CMD_WRITE_VERTEX: begin
                is_write = 1'b1;
            end
            rth_pkg::CMD_LOAD_RAY: begin
                is_load = 1'b1;
            end
            rth_pkg::CMD_TEST: begin
                is_test = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // A corner outside the store turns the test into a miss
    assign idx_ok = (32'(s_item.first_index) < rth_pkg::VERTEX_COUNT)
                 && (32'(s_item.second_index) < rth_pkg::VERTEX_COUNT)
                 && (32'(s_item.third_index) < rth_pkg::VERTEX_COUNT);

    assign wr_vec.x = rth_pkg::coord_in(s_item.pos_x);
    assign wr_vec.y = rth_pkg::coord_in(s_item.pos_y);
    assign wr_vec.z = rth_pkg::coord_in(s_item.pos_z);

    // Configuration and ray state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_distance_reg <= rth_pkg::DIST_W'(1);
            org_reg          <= '0;
            dir_reg          <= '0;
        end else begin
            if (cfg_wr_en) begin
                min_distance_reg <= cfg_wr_data;
            end
            if (s_xfer && is_load) begin
                org_reg   <= wr_vec;
                dir_reg.x <= rth_pkg::coord_in(s_item.dir_x);
                dir_reg.y <= rth_pkg::coord_in(s_item.dir_y);
                dir_reg.z <= rth_pkg::coord_in(s_item.dir_z);
            end
        end
    end

    // Vertex store: one copy per corner so all three read in the same cycle
    rth_ram #(.WIDTH(rth_pkg::VERT_W), .DEPTH(rth_pkg::VERTEX_COUNT)) u_store0 (
        .aclk    (aclk),
        .wr_en   (s_xfer && is_write && (32'(s_item.first_index) < rth_pkg::VERTEX_COUNT)),
        .wr_addr (s_item.first_index[rth_pkg::ADDR_W-1:0]),
        .wr_data (wr_vec),
        .rd_en   (pipe_en),
        .rd_addr (s_item.first_index[rth_pkg::ADDR_W-1:0]),
        .rd_data (v0_raw)
    );

    rth_ram #(.WIDTH(rth_pkg::VERT_W), .DEPTH(rth_pkg::VERTEX_COUNT)) u_store1 (
        .aclk    (aclk),
        .wr_en   (s_xfer && is_write && (32'(s_item.first_index) < rth_pkg::VERTEX_COUNT)),
        .wr_addr (s_item.first_index[rth_pkg::ADDR_W-1:0]),
        .wr_data (wr_vec),
        .rd_en   (pipe_en),
        .rd_addr (s_item.second_index[rth_pkg::ADDR_W-1:0]),
        .rd_data (v1_raw)
    );

    rth_ram #(.WIDTH(rth_pkg::VERT_W), .DEPTH(rth_pkg::VERTEX_COUNT)) u_store2 (
        .aclk    (aclk),
        .wr_en   (s_xfer && is_write && (32'(s_item.first_index) < rth_pkg::VERTEX_COUNT)),
        .wr_addr (s_item.first_index[rth_pkg::ADDR_W-1:0]),
        .wr_data (wr_vec),
        .rd_en   (pipe_en),
        .rd_addr (s_item.third_index[rth_pkg::ADDR_W-1:0]),
        .rd_data (v2_raw)
    );

    // Stage 1: capture the ray alongside the store read so later loads
    // do not disturb tests in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg <= '0;
        end else if (pipe_en) begin
            s1_tag_reg.valid <= s_xfer && is_test;
            s1_tag_reg.ok    <= idx_ok;
            s1_tag_reg.sat   <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_org_reg <= org_reg;
            s1_dir_reg <= dir_reg;
        end
    end

    rth_cramer u_cramer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (pipe_en),
        .tag_i   (s1_tag_reg),
        .v0_i    (rth_pkg::vec_t'(v0_raw)),
        .v1_i    (rth_pkg::vec_t'(v1_raw)),
        .v2_i    (rth_pkg::vec_t'(v2_raw)),
        .org_i   (s1_org_reg),
        .dir_i   (s1_dir_reg),
        .tag_o   (cr_tag),
        .den_o   (cr_den),
        .e1_o    (cr_e1),
        .e2_o    (cr_e2),
        .e3_o    (cr_e3)
    );

    // Stage H: flip signs so the determinant is non-negative; drop zero
    assign den_neg = cr_den[rth_pkg::SUM_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_tag_reg <= '0;
            i_tag_reg <= '0;
            j_tag_reg <= '0;
        end else if (pipe_en) begin
            h_tag_reg.valid <= cr_tag.valid;
            h_tag_reg.ok    <= cr_tag.ok && (cr_den != '0);
            h_tag_reg.sat   <= 1'b0;

            i_tag_reg.valid <= h_tag_reg.valid;
            i_tag_reg.ok    <= h_tag_reg.ok && !h_e1_reg[rth_pkg::SUM_W-1]
                             && !h_e2_reg[rth_pkg::SUM_W-1]
                             && !h_e3_reg[rth_pkg::SUM_W-1];
            // t saturates when e3 >= den * 2^15, i.e. num >= den * 2^31
            i_tag_reg.sat   <= ((rth_pkg::SUM_W + rth_pkg::SAT_SH)'(unsigned'(h_e3_reg))
                               >= {h_den_reg, rth_pkg::SAT_SH'(0)});

            j_tag_reg.valid <= i_tag_reg.valid;
            j_tag_reg.ok    <= i_tag_reg.ok && ({1'b0, i_den_reg} >= i_sum_reg);
            j_tag_reg.sat   <= i_tag_reg.sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            h_den_reg <= den_neg ? (rth_pkg::SUM_W'(0) - unsigned'(cr_den)) : unsigned'(cr_den);
            h_e1_reg  <= den_neg ? -cr_e1 : cr_e1;
            h_e2_reg  <= den_neg ? -cr_e2 : cr_e2;
            h_e3_reg  <= den_neg ? -cr_e3 : cr_e3;

            i_den_reg <= h_den_reg;
            i_e3_reg  <= unsigned'(h_e3_reg);
            i_sum_reg <= unsigned'((rth_pkg::SUM_W + 1)'(h_e1_reg)
                                 + (rth_pkg::SUM_W + 1)'(h_e2_reg));

            // Long division starts with the dividend bits above the quotient
            j_den_reg  <= i_den_reg;
            j_rem_reg  <= rth_pkg::SUM_W'(i_e3_reg[rth_pkg::SUM_W-1:rth_pkg::SAT_SH]);
            j_word_reg <= {i_e3_reg[rth_pkg::SAT_SH-1:0], rth_pkg::T_FRAC_W'(0)};
        end
    end

    rth_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (pipe_en),
        .tag_i   (j_tag_reg),
        .den_i   (j_den_reg),
        .rem_i   (j_rem_reg),
        .word_i  (j_word_reg),
        .tag_o   (dv_tag),
        .quo_o   (dv_quo)
    );

    // Final stage: t >= min_distance holds exactly when floor(t) >= min_distance
    assign fin_hit = dv_tag.ok && (dv_tag.sat || (dv_quo >= rth_pkg::T_W'(min_distance_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            fin_valid_reg <= dv_tag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            fin_item_reg.hit          <= fin_hit;
            fin_item_reg.hit_distance <= !fin_hit ? '0 : (dv_tag.sat ? rth_pkg::T_MAX : dv_quo);
        end
    end

    // Output register plus one skid slot: a result waiting on m_ready does not
    // stop the pipeline; only a second waiting result holds it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= fin_valid_reg;
            end
        end else if (pipe_en && fin_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_item_reg <= skid_valid_reg ? skid_item_reg : fin_item_reg;
        end
        if (m_valid_reg && !m_ready && pipe_en) begin
            skid_item_reg <= fin_item_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[src/rth_checker.sv]
// Port-level checker for the ray/triangle hit test block, bound to the top.
// Depends on rth_pkg and ray_triangle_hit_test_macros.svh.
`include "ray_triangle_hit_test_macros.svh"

module rth_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input rth_pkg::out_item_t m_item
);

    // hold a stalled result
    `RTH_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_item), "result dropped or changed while stalled")

    // a miss carries no distance
    `RTH_ASSERT_IMP(a_miss_zero, m_valid && !m_item.hit, m_item.hit_distance == '0, "miss with nonzero distance")

    // input stalls only behind a held result
    `RTH_ASSERT_IMP(a_stall_full, !s_ready, m_valid, "input stalled with no result waiting")

    // the skid slot fills only when the output was held
    `RTH_ASSERT_IMP(a_stall_cause, $fell(s_ready), $past(m_valid && !m_ready), "input stalled without a held result")

endmodule

bind ray_triangle_hit_test rth_checker u_rth_checker (.*);

[tb/ray_triangle_hit_test_check.sv]
// Checker for the ray/triangle hit test block: mirrors the vertex store, the ray
// and min_distance, predicts each test result and compares it in order.
// Depends on rth_pkg for the channel structs and the command codes.
module ray_triangle_hit_test_check (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  rth_pkg::in_item_t          s_item,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  rth_pkg::out_item_t         m_item,
    input  logic                       cfg_wr_en,
    input  logic [rth_pkg::DIST_W-1:0] cfg_wr_data,
    output int                         fail_count,
    output int                         results_due
);
    import rth_pkg::*;

    typedef logic signed [255:0] big_t;

    vec_t              vertex_mirror [VERTEX_COUNT];
    vec_t              ray_org;
    vec_t              ray_dir;
    logic [DIST_W-1:0] min_dist;
    out_item_t         due_hits [$];

    assign results_due = due_hits.size();

    initial fail_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Exact Cramer solve on wide integers; t is floor(e3 * 2^16 / den).
    function automatic out_item_t hit_of(input vec_t v0, input vec_t v1, input vec_t v2,
                                         input vec_t org, input vec_t dir,
                                         input logic [DIST_W-1:0] mind);
        big_t a, b, c, d, e, f, g, h, i, j, k, l;
        big_t m, n, p, q, r, s, den, e1, e2, e3, num;
        out_item_t res;
        res = '0;
        a = big_t'(v0.x) - big_t'(v1.x);
        b = big_t'(v0.x) - big_t'(v2.x);
        c = big_t'(dir.x);
        d = big_t'(v0.x) - big_t'(org.x);
        e = big_t'(v0.y) - big_t'(v1.y);
        f = big_t'(v0.y) - big_t'(v2.y);
        g = big_t'(dir.y);
        h = big_t'(v0.y) - big_t'(org.y);
        i = big_t'(v0.z) - big_t'(v1.z);
        j = big_t'(v0.z) - big_t'(v2.z);
        k = big_t'(dir.z);
        l = big_t'(v0.z) - big_t'(org.z);
        m = f * k - g * j;
        n = h * k - g * l;
        p = f * l - h * j;
        q = g * i - e * k;
        s = e * j - f * i;
        r = e * l - h * i;
        den = a * m + b * q + c * s;
        e1 = d * m - b * n - c * p;
        e2 = a * n + d * q + c * r;
        e3 = a * p - b * r + d * s;
        if (den == 0)
            return res;
        if (den < 0) begin
            den = -den;
            e1 = -e1;
            e2 = -e2;
            e3 = -e3;
        end
        if (e1 < 0 || e2 < 0 || e1 + e2 > den)
            return res;
        num = e3 <<< 16;
        if (num < big_t'({1'b0, mind}) * den)
            return res;
        res.hit = 1'b1;
        if (num >= (den <<< 31))
            res.hit_distance = T_MAX;
        else
            res.hit_distance = T_W'(num / den);
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            ray_org  <= '0;
            ray_dir  <= '0;
            min_dist <= DIST_W'(1);
            due_hits.delete();
        end else begin
            if (cfg_wr_en)
                min_dist <= cfg_wr_data;
            if (m_valid && m_ready) begin
                if (due_hits.size() == 0) begin
                    report_mismatch("unexpected result", longint'(m_item), 0);
                end else begin
                    if (m_item.hit !== due_hits[0].hit)
                        report_mismatch("hit", m_item.hit, due_hits[0].hit);
                    if (m_item.hit_distance !== due_hits[0].hit_distance)
                        report_mismatch("hit_distance", m_item.hit_distance,
                                        due_hits[0].hit_distance);
                    void'(due_hits.pop_front());
                end
            end
            if (s_valid && s_ready) begin
                case (s_item.cmd)
                    CMD_WRITE_VERTEX: begin
                        vertex_mirror[s_item.first_index] <= '{z: s_item.pos_z,
                            y: s_item.pos_y, x: s_item.pos_x};
                    end
                    CMD_LOAD_RAY: begin
                        ray_org <= '{z: s_item.pos_z, y: s_item.pos_y, x: s_item.pos_x};
                        ray_dir <= '{z: s_item.dir_z, y: s_item.dir_y, x: s_item.dir_x};
                    end
                    CMD_TEST: begin
                        due_hits.push_back(hit_of(vertex_mirror[s_item.first_index],
                            vertex_mirror[s_item.second_index],
                            vertex_mirror[s_item.third_index], ray_org, ray_dir, min_dist));
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

[tb/ray_triangle_hit_test_test.sv]
// Top of the ray/triangle hit test bench: clock, reset, stimulus, receiver
// stalls and the verdict. Depends on rth_pkg, the block and the checker.
module ray_triangle_hit_test_test;
    import rth_pkg::*;

    localparam int ONE        = 1 << 16;   // 1.0 in Q16.16
    localparam int DRAIN_WAIT = 60;        // pipeline depth plus margin
    localparam int CYCLE_CAP  = 500000;
    localparam int PHASE_ITEMS = 190;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_item = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_item;
    logic              cfg_wr_en = 1'b0;
    logic [DIST_W-1:0] cfg_wr_data = '0;

    int  fail_count;
    int  results_due;
    int  cycle_count = 0;
    int  sent_count = 0;
    int  burst_left = 0;
    bit  seen [VERTEX_COUNT];
    int  written_idx [$];

    always #4 aclk = ~aclk;

    ray_triangle_hit_test dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    ray_triangle_hit_test_check checker_inst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .fail_count (fail_count),
        .results_due(results_due)
    );

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: change stall mode every so often, with fully-ready stretches.
    // Around item 300, hold off for a long stretch so the pipeline backs up
    // into s_ready while the sender keeps offering.
    int  hold_left = 0;
    int  mode_left = 0;
    int  stall_mode = 0;
    bit  long_hold_done = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!long_hold_done && sent_count >= 300) begin
            long_hold_done = 1'b1;
            hold_left = 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(20, 200);
                stall_mode = $urandom_range(0, 3);
            end
            mode_left--;
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 1) != 0);
                default: m_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Offer one item and hold it until the transfer; bursts with random gaps.
    // Called at a clock edge; returns at the edge of the transfer, so the
    // next item of a burst is driven in the same step and follows back to back.
    task automatic send(input in_item_t it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_item  <= it;
        sent_count++;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic in_item_t make_item(input logic [CMD_W-1:0] cmd, input int i0,
                                           input int i1, input int i2,
                                           input int px, input int py, input int pz,
                                           input int dx, input int dy, input int dz);
        in_item_t it;
        it.cmd = cmd;
        it.first_index = INDEX_W'(i0);
        it.second_index = INDEX_W'(i1);
        it.third_index = INDEX_W'(i2);
        it.pos_x = px;
        it.pos_y = py;
        it.pos_z = pz;
        it.dir_x = dx;
        it.dir_y = dy;
        it.dir_z = dz;
        return it;
    endfunction

    task automatic write_vertex(input int idx, input int px, input int py, input int pz);
        if (!seen[idx]) begin
            seen[idx] = 1'b1;
            written_idx.push_back(idx);
        end
        send(make_item(CMD_WRITE_VERTEX, idx, $urandom, $urandom, px, py, pz,
                       $urandom, $urandom, $urandom));
    endtask

    task automatic load_ray(input int px, input int py, input int pz,
                            input int dx, input int dy, input int dz);
        send(make_item(CMD_LOAD_RAY, $urandom, $urandom, $urandom, px, py, pz, dx, dy, dz));
    endtask

    task automatic test_tri(input int i0, input int i1, input int i2);
        send(make_item(CMD_TEST, i0, i1, i2, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom));
    endtask

    // Drop valid at the last transfer and write the register only once the
    // pipeline has drained.
    task automatic set_min_distance(input logic [DIST_W-1:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (results_due == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic int span(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int pick_written();
        return written_idx[$urandom_range(0, written_idx.size() - 1)];
    endfunction

    task automatic directed_items();
        // Right triangle of side 4 in the z = 0 plane.
        write_vertex(0, 0, 0, 0);
        write_vertex(1, 4 * ONE, 0, 0);
        write_vertex(2, 0, 4 * ONE, 0);
        load_ray(ONE, ONE, -8 * ONE, 0, 0, ONE);
        test_tri(0, 1, 2);                       // plain hit, t = 8
        test_tri(0, 2, 1);                       // reversed winding
        test_tri(0, 0, 1);                       // degenerate, zero determinant
        load_ray(0, 0, -8 * ONE, 0, 0, ONE);
        test_tri(0, 1, 2);                       // through a corner
        load_ray(2 * ONE, 2 * ONE, -8 * ONE, 0, 0, ONE);
        test_tri(0, 1, 2);                       // on the long edge
        load_ray(5 * ONE, 5 * ONE, -8 * ONE, 0, 0, ONE);
        test_tri(0, 1, 2);                       // outside
        load_ray(ONE, ONE, 8 * ONE, 0, 0, ONE);
        test_tri(0, 1, 2);                       // triangle behind the origin
        load_ray(ONE, ONE, -1, 0, 0, ONE);
        test_tri(0, 1, 2);                       // t equals min_distance
        load_ray(ONE, ONE, 0, 0, 0, ONE);
        test_tri(0, 1, 2);                       // t of zero, below min_distance
        load_ray(ONE, ONE, -8 * ONE, 0, 0, 1);
        test_tri(0, 1, 2);                       // tiny direction, t saturates
        load_ray(ONE, ONE, -8 * ONE, 0, 0, 0);
        test_tri(0, 1, 2);                       // zero direction
        send(make_item(CMD_IGNORED, 0, 1, 2, 0, 0, 0, 0, 0, 0));   // unused command
        write_vertex(1021, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        write_vertex(1022, 32'h80000000, 32'h7fffffff, 32'h80000000);
        write_vertex(1023, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        load_ray(32'h80000000, 32'h80000000, 32'h7fffffff,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        test_tri(1021, 1022, 1023);              // extremes of every coordinate
    endtask

    // Mostly small scenes around a ray running along +z so hits are common;
    // a share of full-range values covers every bit of every field.
    task automatic random_item();
        int  sel;
        bit  wild;
        sel  = $urandom_range(0, 99);
        wild = ($urandom_range(0, 9) == 0);
        if (sel < 30) begin
            if (wild)
                write_vertex($urandom_range(0, VERTEX_COUNT - 1), $urandom, $urandom, $urandom);
            else
                write_vertex($urandom_range(0, VERTEX_COUNT - 1), span(-3 * ONE, 3 * ONE),
                             span(-3 * ONE, 3 * ONE), span(-ONE, ONE));
        end else if (sel < 40) begin
            if (wild)
                load_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                load_ray(span(-ONE - ONE / 2, ONE + ONE / 2),
                         span(-ONE - ONE / 2, ONE + ONE / 2),
                         span(-6 * ONE, -ONE / 4), span(-ONE / 4, ONE / 4),
                         span(-ONE / 4, ONE / 4), span(ONE / 4, 2 * ONE));
        end else if (sel < 95) begin
            test_tri(pick_written(), pick_written(), pick_written());
        end else begin
            send(make_item(CMD_IGNORED, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom));
        end
    endtask

    initial begin : stimulus
        logic [DIST_W-1:0] settings [5];
        settings[0] = DIST_W'(1);
        settings[1] = '0;
        settings[2] = '1;
        settings[3] = DIST_W'($urandom);
        settings[4] = DIST_W'(ONE / 2);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        directed_items();
        for (int ph = 0; ph < 5; ph++) begin
            set_min_distance(settings[ph]);
            if (ph == 1)
                directed_items();                // re-run the edge cases at zero
            repeat (PHASE_ITEMS) random_item();
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (results_due == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[ray_triangle_hit_test.f]
+incdir+src
src/rth_pkg.sv
src/rth_ram.sv
src/rth_cramer.sv
src/rth_divider.sv
src/ray_triangle_hit_test.sv
src/rth_checker.sv
tb/ray_triangle_hit_test_check.sv
tb/ray_triangle_hit_test_test.sv
